// ===== sv/tcmac_pkg.sv =====
package tcmac_pkg;

  localparam int QUEUE_LIMIT = 10;

  // action codes
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_RX_FRAME = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // mac modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CONTEND = 2'd1;
  localparam logic [1:0] MODE_BKOFF = 2'd2;
  localparam logic [1:0] MODE_ENDFRAME = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_CR_WINDOW = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME = 2'd2;

  localparam logic [7:0] BCAST_ADDRESS = 8'hFF;
  localparam logic [7:0] CONTENDERS_MAX = 8'hFF;

  localparam logic [7:0] OWN_ADDRESS_RST = 8'd1;
  localparam logic [15:0] CR_WINDOW_RST = 16'd494;
  localparam logic [23:0] MAX_FRAME_RST = 24'd14820;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  dest_address;
    logic        phy_busy;
    logic [15:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic       send_tone;
    logic       send_data;
    logic       deliver_up;
    logic       enqueue_dropped;
    logic [1:0] mac_mode;
    logic [3:0] queued_count;
    logic [7:0] contender_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== sv/tcmac_ctrl.sv =====
module tcmac_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcmac_pkg::ctrl_cmd_t cmd_o
);
  import tcmac_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic capture, commit;

  assign capture = (state_q == S_IDLE) && in_valid_i;
  // result register free or being drained this cycle
  assign commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (capture) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.commit  = commit;

endmodule

// ===== sv/tcmac_dp.sv =====
module tcmac_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tcmac_pkg::ctrl_cmd_t cmd_i,
  input  tcmac_pkg::in_item_t  in_item_i,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  output tcmac_pkg::out_item_t out_item_o
);
  import tcmac_pkg::*;

  // configuration
  logic [7:0]  own_addr_q;
  logic [15:0] cr_window_q;
  logic [23:0] max_frame_q;

  // mac state
  logic [1:0]  mode_q, mode_d;
  logic        blocked_q, blocked_d;
  logic [7:0]  contenders_q, contenders_d;
  logic [3:0]  fill_q, fill_d;
  logic        rr_run_q, rr_run_d;
  logic [15:0] rr_cnt_q, rr_cnt_d;
  logic        bk_run_q, bk_run_d;
  logic [23:0] bk_cnt_q, bk_cnt_d;
  logic        fr_run_q, fr_run_d;
  logic [23:0] fr_cnt_q, fr_cnt_d;

  // captured item and first backoff product
  in_item_t    item_q;
  logic [7:0]  draw_q;
  logic [23:0] draw_prod;
  logic [23:0] bk_load;

  out_item_t   res_d, res_q;
  logic        tone, data, deliver, dropped;
  logic        ef, er, eb;

  assign draw_prod = in_item_i.random_fraction * contenders_q;
  assign bk_load   = draw_q * cr_window_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
      draw_q <= draw_prod[23:16];
    end
    if (cmd_i.commit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= OWN_ADDRESS_RST;
      cr_window_q <= CR_WINDOW_RST;
      max_frame_q <= MAX_FRAME_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_ADDRESS: own_addr_q  <= cfg_data_i[7:0];
        CFG_CR_WINDOW:   cr_window_q <= cfg_data_i[15:0];
        CFG_MAX_FRAME:   max_frame_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d       = mode_q;
    blocked_d    = blocked_q;
    contenders_d = contenders_q;
    fill_d       = fill_q;
    rr_run_d     = rr_run_q;
    rr_cnt_d     = rr_cnt_q;
    bk_run_d     = bk_run_q;
    bk_cnt_d     = bk_cnt_q;
    fr_run_d     = fr_run_q;
    fr_cnt_d     = fr_cnt_q;
    tone         = 1'b0;
    data         = 1'b0;
    deliver      = 1'b0;
    dropped      = 1'b0;
    ef           = 1'b0;
    er           = 1'b0;
    eb           = 1'b0;

    unique case (item_q.action)
      ACT_ENQUEUE: begin
        if (fill_q < 4'(QUEUE_LIMIT)) fill_d = fill_q + 4'd1;
        else dropped = 1'b1;
        if (blocked_q && !fr_run_q) begin
          fr_run_d = 1'b1;
          fr_cnt_d = max_frame_q;
          mode_d   = MODE_ENDFRAME;
        end
        if ((mode_d == MODE_IDLE && !blocked_d) || !(rr_run_d || bk_run_d || fr_run_d)) begin
          tone = 1'b1; rr_run_d = 1'b1; rr_cnt_d = cr_window_q;
          mode_d = MODE_CONTEND; contenders_d = 8'd1;
        end
      end
      ACT_RX_FRAME: begin
        priority if (item_q.dest_address == BCAST_ADDRESS) begin
          // tone heard
          if (!blocked_q) begin
            if (mode_q == MODE_IDLE || mode_q == MODE_BKOFF) begin
              if (mode_q == MODE_BKOFF) begin
                bk_run_d = 1'b0; bk_cnt_d = '0;
              end
              blocked_d = 1'b1;
              fr_run_d  = 1'b1;
              fr_cnt_d  = max_frame_q;
              mode_d    = MODE_ENDFRAME;
            end else if (mode_q == MODE_CONTEND) begin
              if (contenders_q < CONTENDERS_MAX) contenders_d = contenders_q + 8'd1;
            end
          end
        end else if (item_q.dest_address == own_addr_q) begin
          deliver = 1'b1;
        end else begin
          // data frame for another node ends the exchange
          if (blocked_q) begin
            blocked_d = 1'b0; fr_run_d = 1'b0; fr_cnt_d = '0;
          end
          rr_run_d = 1'b0; rr_cnt_d = '0;
          bk_run_d = 1'b0; bk_cnt_d = '0;
          if (fill_q != 4'd0) begin
            tone = 1'b1; rr_run_d = 1'b1; rr_cnt_d = cr_window_q;
            mode_d = MODE_CONTEND; contenders_d = 8'd1;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
      end
      ACT_TICK: begin
        if (fr_run_q) begin
          if (fr_cnt_q > 24'd1) fr_cnt_d = fr_cnt_q - 24'd1;
          else begin
            fr_run_d = 1'b0; fr_cnt_d = '0; ef = 1'b1;
          end
        end
        if (rr_run_q) begin
          if (rr_cnt_q > 16'd1) rr_cnt_d = rr_cnt_q - 16'd1;
          else begin
            rr_run_d = 1'b0; rr_cnt_d = '0; er = 1'b1;
          end
        end
        if (bk_run_q) begin
          if (bk_cnt_q > 24'd1) bk_cnt_d = bk_cnt_q - 24'd1;
          else begin
            bk_run_d = 1'b0; bk_cnt_d = '0; eb = 1'b1;
          end
        end
        // frame end, then round end, then backoff end
        if (ef && !fr_run_d) begin
          blocked_d = 1'b0;
          if (fill_d != 4'd0) begin
            tone = 1'b1; rr_run_d = 1'b1; rr_cnt_d = cr_window_q;
            mode_d = MODE_CONTEND; contenders_d = 8'd1;
          end else begin
            mode_d = MODE_IDLE;
          end
        end
        if (er && !rr_run_d) begin
          priority if (contenders_d > 8'd1) begin
            bk_run_d = 1'b1; bk_cnt_d = bk_load; mode_d = MODE_BKOFF;
          end else if (fill_d == 4'd0) begin
            mode_d = MODE_IDLE;
          end else if (!item_q.phy_busy) begin
            data = 1'b1; fill_d = fill_d - 4'd1; mode_d = MODE_IDLE;
          end else begin
            tone = 1'b1; rr_run_d = 1'b1; rr_cnt_d = cr_window_q;
            mode_d = MODE_CONTEND; contenders_d = 8'd1;
          end
        end
        if (eb && !bk_run_d) begin
          tone = 1'b1; rr_run_d = 1'b1; rr_cnt_d = cr_window_q;
          mode_d = MODE_CONTEND; contenders_d = 8'd1;
        end
      end
      default: ;
    endcase

    res_d.send_tone       = tone;
    res_d.send_data       = data;
    res_d.deliver_up      = deliver;
    res_d.enqueue_dropped = dropped;
    res_d.mac_mode        = mode_d;
    res_d.queued_count    = fill_d;
    res_d.contender_count = contenders_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      blocked_q    <= 1'b0;
      contenders_q <= 8'd1;
      fill_q       <= '0;
      rr_run_q     <= 1'b0;
      rr_cnt_q     <= '0;
      bk_run_q     <= 1'b0;
      bk_cnt_q     <= '0;
      fr_run_q     <= 1'b0;
      fr_cnt_q     <= '0;
    end else if (cmd_i.commit) begin
      mode_q       <= mode_d;
      blocked_q    <= blocked_d;
      contenders_q <= contenders_d;
      fill_q       <= fill_d;
      rr_run_q     <= rr_run_d;
      rr_cnt_q     <= rr_cnt_d;
      bk_run_q     <= bk_run_d;
      bk_cnt_q     <= bk_cnt_d;
      fr_run_q     <= fr_run_d;
      fr_cnt_q     <= fr_cnt_d;
    end
  end

  assign out_item_o = res_q;

endmodule

// ===== sv/tone_contention_mac_controller.sv =====
// timing: an item is captured into the datapath when it is taken, and its result
//   is registered once the result register is free or being drained
// flow: a new item is stalled until the current one has committed; the backoff
//   draw (random times contender count) is registered before it is scaled by
//   the round window
// reset: rst_ni clears the mac state to idle with stopped timers and loads the
//   default own address, round window and frame timeout
module tone_contention_mac_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tcmac_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcmac_pkg::out_item_t out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i
);
  import tcmac_pkg::*;

  ctrl_cmd_t cmd;

  tcmac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tcmac_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_item_o  (out_item_o)
  );

  // configuration writes complete at once
  assign cfg_ready_o = 1'b1;

endmodule
